FILE: rtl/core/ctpd_pkg.sv
// Shared types, codes and constants of the capacitive touch and proximity detector.
package ctpd_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [15:0] DRIFT_STEP       = 16'd1;
    localparam logic [15:0] RISE_INTERVAL_MS = 16'd100;
    localparam logic [15:0] FALL_INTERVAL_MS = 16'd50;

    localparam logic [15:0] BASELINE_RESET = 16'd200;
    localparam logic [7:0]  RATIO_FULL     = 8'd255;
    localparam logic [7:0]  WEIGHT_FULL    = 8'd255;

    // Two quotient bits are resolved per divider step.
    localparam int unsigned DIV_STEPS = 4;

    // Field positions in the result tdata.
    localparam int unsigned OUT_STATE_LSB = 16;
    localparam int unsigned OUT_TOUCHED   = 19;
    localparam int unsigned OUT_JTOUCH    = 20;
    localparam int unsigned OUT_JRELEASE  = 21;
    localparam int unsigned OUT_RATIO_LSB = 22;

    typedef enum logic [2:0] {
        CLS_IDLE  = 3'd0,
        CLS_BASE  = 3'd1,
        CLS_RISE  = 3'd2,
        CLS_FALL  = 3'd3,
        CLS_PROX  = 3'd4,
        CLS_TOUCH = 3'd5
    } cls_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EXP_WEIGHT    = 3'd0,
        CFG_NOISE_DELTA   = 3'd1,
        CFG_TOUCH_TH      = 3'd2,
        CFG_TOUCH_REL_TH  = 3'd3,
        CFG_PROX_TH       = 3'd4,
        CFG_PROX_REL_TH   = 3'd5,
        CFG_DEBOUNCE_MS   = 3'd6,
        CFG_RESET_DELAY   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  exp_weight;
        logic [15:0] noise_delta;
        logic [14:0] touch_threshold;
        logic [14:0] touch_release_threshold;
        logic [14:0] prox_threshold;
        logic [14:0] prox_release_threshold;
        logic [15:0] debounce_ms;
        logic [31:0] reset_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic estimate;
        logic filter;
        logic classify;
        logic div_step;
        logic load_out;
    } cmd_t;

endpackage

FILE: rtl/core/ctpd_cfg.sv
// Configuration register file of the detector.
module ctpd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [ctpd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ctpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output ctpd_pkg::cfg_t                 cfg
);
    import ctpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_EXP_WEIGHT:   cfg_next.exp_weight = cfg_wdata[7:0];
                CFG_NOISE_DELTA:  cfg_next.noise_delta = cfg_wdata[15:0];
                CFG_TOUCH_TH:     cfg_next.touch_threshold = cfg_wdata[14:0];
                CFG_TOUCH_REL_TH: cfg_next.touch_release_threshold = cfg_wdata[14:0];
                CFG_PROX_TH:      cfg_next.prox_threshold = cfg_wdata[14:0];
                CFG_PROX_REL_TH:  cfg_next.prox_release_threshold = cfg_wdata[14:0];
                CFG_DEBOUNCE_MS:  cfg_next.debounce_ms = cfg_wdata[15:0];
                CFG_RESET_DELAY:  cfg_next.reset_delay_ms = cfg_wdata[31:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exp_weight              <= 8'd128;
            cfg_reg.noise_delta             <= 16'd2;
            cfg_reg.touch_threshold         <= 15'd100;
            cfg_reg.touch_release_threshold <= 15'd60;
            cfg_reg.prox_threshold          <= 15'd10;
            cfg_reg.prox_release_threshold  <= 15'd7;
            cfg_reg.debounce_ms             <= 16'd20;
            cfg_reg.reset_delay_ms          <= 32'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/ctpd_ctrl.sv
// Sequencing state machine of the detector.
module ctpd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output ctpd_pkg::cmd_t cmd
);
    import ctpd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_ESTIMATE = 6'b000010,
        ST_FILTER   = 6'b000100,
        ST_CLASSIFY = 6'b001000,
        ST_DIVIDE   = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_ESTIMATE;
                end
            end
            ST_ESTIMATE:
            begin
                cmd.estimate = 1'b1;
                state_next   = ST_FILTER;
            end
            ST_FILTER:
            begin
                cmd.filter = 1'b1;
                state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

endmodule

FILE: rtl/core/ctpd_dp.sv
// Datapath: filter, baseline tracking, classification, debounce and ratio divider.
module ctpd_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ctpd_pkg::cfg_t                  cfg,
    input  ctpd_pkg::cmd_t                  cmd,
    input  logic [ctpd_pkg::IN_DATA_W-1:0]  in_data,
    output logic [ctpd_pkg::OUT_DATA_W-1:0] out_data
);
    import ctpd_pkg::*;

    // Item registers.
    logic [31:0] now_reg;
    logic [23:0] sum_reg;
    logic [15:0] qest_reg;
    logic signed [15:0] delta_reg;
    logic [31:0] elapsed_reg;

    // Tracking state.
    logic [15:0] filt_reg, filt_next;
    logic [15:0] base_reg, base_next;
    cls_t        inst_reg, cls_fin;
    cls_t        comm_reg;
    cls_t        prior_reg;
    logic [31:0] start_reg, start_next;

    // Ratio divider.
    logic [15:0] rem_reg, span_reg;
    logic [7:0]  quo_reg;
    logic        rzero_reg, rsat_reg;

    logic [OUT_DATA_W-1:0] out_reg;

    // Filter sum and divide by 255 through a reciprocal estimate.
    logic [15:0] reading;
    logic [23:0] sum_new;
    logic [24:0] est_sum;
    logic [24:0] est_rem;

    assign reading = in_data[15:0];
    assign sum_new = ({8'b0, reading} * {16'b0, cfg.exp_weight})
                   + ({8'b0, filt_reg} * {16'b0, WEIGHT_FULL - cfg.exp_weight});
    assign est_sum = {1'b0, sum_reg} + {9'b0, sum_reg[23:8]} + {17'b0, sum_reg[23:16]};
    assign est_rem = {1'b0, sum_reg} - ({1'b0, qest_reg, 8'b0} - {9'b0, qest_reg});
    assign filt_next = qest_reg + {15'b0, (est_rem >= 25'd255)};

    // Classification.
    logic signed [15:0] touch_s, trel_s, prox_s, prel_s;
    logic [16:0] mag;
    cls_t        cls1;
    logic        same_cls, held, drift, commit;
    logic [31:0] el_use;

    assign touch_s = signed'({1'b0, cfg.touch_threshold});
    assign trel_s  = signed'({1'b0, cfg.touch_release_threshold});
    assign prox_s  = signed'({1'b0, cfg.prox_threshold});
    assign prel_s  = signed'({1'b0, cfg.prox_release_threshold});
    assign mag = delta_reg[15] ? (17'(~delta_reg) + 17'd1) : {1'b0, delta_reg};

    always_comb
    begin
        priority if (mag <= {1'b0, cfg.noise_delta})
        begin
            cls1 = CLS_BASE;
        end
        else if (delta_reg > touch_s)
        begin
            cls1 = CLS_TOUCH;
        end
        else if (delta_reg > prox_s)
        begin
            cls1 = CLS_PROX;
        end
        else if (delta_reg > 16'sd0)
        begin
            cls1 = CLS_RISE;
        end
        else if (delta_reg < 16'sd0)
        begin
            cls1 = CLS_FALL;
        end
        else
        begin
            cls1 = CLS_IDLE;
        end
    end

    assign same_cls = (cls1 == inst_reg);
    assign el_use   = same_cls ? elapsed_reg : 32'd0;
    assign held     = (el_use > cfg.reset_delay_ms);

    always_comb
    begin
        cls_fin    = cls1;
        base_next  = base_reg;
        start_next = same_cls ? start_reg : now_reg;
        drift      = 1'b0;
        unique case (cls1)
            CLS_BASE:
            begin
                base_next = filt_reg;
            end
            CLS_TOUCH:
            begin
                if (held)
                begin
                    base_next = filt_reg;
                end
                if (delta_reg < trel_s)
                begin
                    cls_fin = (delta_reg > prel_s) ? CLS_PROX : CLS_IDLE;
                end
            end
            CLS_PROX:
            begin
                if (held)
                begin
                    base_next = filt_reg;
                end
                if (delta_reg > touch_s)
                begin
                    cls_fin = CLS_TOUCH;
                end
                else if (delta_reg < prel_s)
                begin
                    cls_fin = CLS_IDLE;
                end
            end
            CLS_RISE:
            begin
                if (el_use[15:0] >= RISE_INTERVAL_MS)
                begin
                    base_next  = base_reg + DRIFT_STEP;
                    start_next = now_reg;
                    drift      = 1'b1;
                end
            end
            CLS_FALL:
            begin
                if (el_use[15:0] >= FALL_INTERVAL_MS)
                begin
                    base_next  = base_reg - DRIFT_STEP;
                    start_next = now_reg;
                    drift      = 1'b1;
                end
            end
            default:
            begin
                cls_fin = cls1;
            end
        endcase
    end

    assign commit = (cls_fin == inst_reg) && !drift && (el_use > {16'b0, cfg.debounce_ms});

    // Ratio setup.
    logic signed [16:0] depth;
    logic signed [15:0] span;
    logic               depth_le0, span_le0;

    assign depth     = {delta_reg[15], delta_reg} - {2'b0, cfg.prox_threshold};
    assign span      = {1'b0, cfg.touch_threshold} - {1'b0, cfg.prox_threshold};
    assign depth_le0 = depth[16] || (depth == 17'sd0);
    assign span_le0  = span[15] || (span == 16'sd0);

    // Two restoring steps per cycle.
    logic [16:0] r1, r1s, r2, r2s;
    logic        b1, b2;

    assign r1  = {rem_reg, 1'b0};
    assign b1  = (r1 >= {1'b0, span_reg});
    assign r1s = b1 ? (r1 - {1'b0, span_reg}) : r1;
    assign r2  = {r1s[15:0], 1'b0};
    assign b2  = (r2 >= {1'b0, span_reg});
    assign r2s = b2 ? (r2 - {1'b0, span_reg}) : r2;

    // Result fields.
    logic [7:0] ratio;
    logic       touched, jtouch, jrelease;

    always_comb
    begin
        unique case (comm_reg)
            CLS_PROX:
            begin
                priority if (rzero_reg)
                begin
                    ratio = 8'd0;
                end
                else if (rsat_reg)
                begin
                    ratio = RATIO_FULL;
                end
                else
                begin
                    ratio = quo_reg;
                end
            end
            CLS_TOUCH: ratio = RATIO_FULL;
            default:   ratio = 8'd0;
        endcase
    end

    assign touched  = (comm_reg == CLS_TOUCH);
    assign jtouch   = touched && (prior_reg != CLS_TOUCH);
    assign jrelease = (comm_reg != CLS_TOUCH) && (comm_reg != CLS_PROX)
                   && ((prior_reg == CLS_TOUCH) || (prior_reg == CLS_PROX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg  <= 16'd0;
            base_reg  <= BASELINE_RESET;
            inst_reg  <= CLS_IDLE;
            comm_reg  <= CLS_IDLE;
            prior_reg <= CLS_IDLE;
            start_reg <= 32'd0;
        end
        else
        begin
            if (cmd.filter)
            begin
                filt_reg <= filt_next;
            end
            if (cmd.classify)
            begin
                base_reg  <= base_next;
                inst_reg  <= cls_fin;
                start_reg <= start_next;
                if (commit)
                begin
                    prior_reg <= comm_reg;
                    comm_reg  <= cls_fin;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            now_reg <= in_data[47:16];
            sum_reg <= sum_new;
        end
        if (cmd.estimate)
        begin
            qest_reg <= est_sum[23:8];
        end
        if (cmd.filter)
        begin
            delta_reg   <= signed'(filt_next - base_reg);
            elapsed_reg <= now_reg - start_reg;
        end
        if (cmd.classify)
        begin
            rem_reg   <= depth[15:0];
            span_reg  <= span;
            quo_reg   <= 8'd0;
            rzero_reg <= depth_le0;
            rsat_reg  <= span_le0 || (depth[15:0] >= span);
        end
        if (cmd.div_step)
        begin
            rem_reg <= r2s[15:0];
            quo_reg <= {quo_reg[5:0], b1, b2};
        end
        if (cmd.load_out)
        begin
            out_reg <= {2'b0, ratio, jrelease, jtouch, touched, comm_reg, delta_reg};
        end
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/core/capacitive_touch_prox_detector.sv
// Top level of the capacitive touch and proximity detector.
// Each reading is taken when s_axis_tready is high; the block then works on
// it alone and is ready for the next one once it has loaded the result
// register, which waits until the previous result has been taken. The
// exponential filter and its divide by 255 come first, then classification,
// baseline tracking and debounce, the prox-ratio divider (two quotient bits a
// cycle) and the load of the result register. The result register frees the
// input side, so a new reading is accepted while a result still waits.
module capacitive_touch_prox_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [ctpd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ctpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // reading[15:0], now_ms[47:16]
    input  logic [ctpd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // delta[15:0], debounced_state[18:16], touched[19], just_touched[20],
    // just_released[21], prox_ratio[29:22], zero[31:30]
    output logic [ctpd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import ctpd_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    ctpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ctpd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    ctpd_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule

FILE: rtl/core/ctpd_checker.sv
// Port-level checks of the detector and their binding to the top level.
module ctpd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ctpd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import ctpd_pkg::*;

    logic [2:0] st;
    logic       touched, jtouch, jrelease;

    assign st       = m_axis_tdata[OUT_STATE_LSB +: 3];
    assign touched  = m_axis_tdata[OUT_TOUCHED];
    assign jtouch   = m_axis_tdata[OUT_JTOUCH];
    assign jrelease = m_axis_tdata[OUT_JRELEASE];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before its transfer");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("reading accepted while the previous one is still in work");

    a_touched_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (touched == (st == CLS_TOUCH)))
        else $error("touched flag disagrees with debounced state");

    a_edge_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!jtouch || touched)
                          && (!jrelease || (st != CLS_TOUCH && st != CLS_PROX)))
        else $error("edge flag disagrees with debounced state");

    a_ratio_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && st != CLS_TOUCH && st != CLS_PROX
        |-> m_axis_tdata[OUT_RATIO_LSB +: 8] == 8'd0)
        else $error("prox ratio set outside touch or prox");

endmodule

bind capacitive_touch_prox_detector ctpd_checker u_ctpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
